### rtl/ray_polygon_nearest_hit_top_assert.svh
`ifndef RAY_POLYGON_NEAREST_HIT_TOP_ASSERT_SVH
`define RAY_POLYGON_NEAREST_HIT_TOP_ASSERT_SVH

// antecedent holds, consequent must hold in the same cycle
`define RPNH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds, consequent must hold in the cycle after
`define RPNH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rpnh_pkg.sv
package rpnh_pkg;

  localparam int CW     = 32;
  localparam int DW     = 16;
  localparam int DF     = 14;
  localparam int EW     = CW + 1;
  localparam int PW     = DW + EW;
  localparam int DEN_W  = PW + 1;
  localparam int MAG_W  = DEN_W;
  localparam int NUM_LO = MAG_W / 2;
  localparam int NUM_HI = MAG_W - NUM_LO;
  localparam int PROD_W = EW + MAG_W;
  localparam int QL     = CW + 8;
  localparam int QB     = QL + 1;
  localparam int QS_W   = QL + 1;
  localparam int CNT_W  = $clog2(QB);
  localparam int PT_W   = QS_W + 1;
  localparam int OFS_W  = CW + 2;
  localparam int SA_W   = OFS_W + DW;
  localparam int SUM_W  = SA_W + 1;
  localparam int T_W    = SUM_W + 1;
  localparam int DIST_W = CW + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [DW-1:0] dir_x;
    logic signed [DW-1:0] dir_y;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic                 emit;
  } edge_job_t;

  typedef struct packed {
    logic                 found;
    logic [DIST_W-1:0]    distance;
    logic signed [CW-1:0] hx;
    logic signed [CW-1:0] hy;
  } nearest_t;

endpackage

### rtl/ray_polygon_nearest_hit_top.sv
// every vertex after the first gives one edge job (two for a closing vertex), a lone
// vertex gives one, on a two-entry queue; two 41-step restoring divisions by the
// determinant dominate the back end's work on an edge, plus multiply and compare steps
// the back end takes a new edge only once done with the last; a vertex is taken while
// the queue has room and no closing edge is pending; a result waits for a free output
// rst (synchronous, active high) clears the registers to their defaults and drops all work
module ray_polygon_nearest_hit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] vertex_x,
  input  logic [31:0] vertex_y,
  input  logic        last_vertex,
  output logic        empty,
  input  logic        pop,
  output logic        fwd_found,
  output logic [32:0] fwd_distance,
  output logic [31:0] fwd_hit_x,
  output logic [31:0] fwd_hit_y,
  output logic        back_found,
  output logic [32:0] back_distance,
  output logic [31:0] back_hit_x,
  output logic [31:0] back_hit_y
);
  import rpnh_pkg::*;

  cfg_t      cfg;
  edge_job_t f_job, q_job;
  logic      f_valid, f_ready, q_valid, q_pop, res_valid;
  nearest_t  res_fwd, res_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x <= '0;
      cfg.origin_y <= '0;
      cfg.dir_x    <= '0;
      cfg.dir_y    <= DW'(-16384);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: cfg.origin_x <= $signed(cfg_data);
        REG_ORIGIN_Y: cfg.origin_y <= $signed(cfg_data);
        REG_DIR_X:    cfg.dir_x    <= $signed(cfg_data[DW-1:0]);
        REG_DIR_Y:    cfg.dir_y    <= $signed(cfg_data[DW-1:0]);
      endcase
    end
  end

  rpnh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex),
    .job_valid   (f_valid),
    .job_ready   (f_ready),
    .job         (f_job)
  );

  rpnh_jobq u_jobq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_job    (f_job),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_job   (q_job)
  );

  rpnh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .job_in    (q_job),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res_fwd   (res_fwd),
    .res_back  (res_back)
  );

  assign empty         = !res_valid;
  assign fwd_found     = res_fwd.found;
  assign fwd_distance  = res_fwd.distance;
  assign fwd_hit_x     = res_fwd.hx;
  assign fwd_hit_y     = res_fwd.hy;
  assign back_found    = res_back.found;
  assign back_distance = res_back.distance;
  assign back_hit_x    = res_back.hx;
  assign back_hit_y    = res_back.hy;

endmodule

### rtl/rpnh_front.sv
module rpnh_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [31:0]           vertex_x,
  input  logic [31:0]           vertex_y,
  input  logic                  last_vertex,
  output logic                  job_valid,
  input  logic                  job_ready,
  output rpnh_pkg::edge_job_t   job
);
  import rpnh_pkg::*;

  logic signed [CW-1:0] first_x, first_y, prev_x, prev_y;
  logic                 have_prev;
  logic                 pend;
  edge_job_t            pend_job;
  logic                 accept;
  logic signed [CW-1:0] vx, vy;

  assign vx     = $signed(vertex_x);
  assign vy     = $signed(vertex_y);
  assign full   = pend || !job_ready;
  assign accept = push && !full;

  always_comb begin
    job_valid = pend || (accept && (have_prev || last_vertex));
    if (pend) begin
      job = pend_job;
    end else if (have_prev) begin
      job = '{ax: prev_x, ay: prev_y, bx: vx, by: vy, emit: 1'b0};
    end else begin
      // lone vertex closes onto itself
      job = '{ax: vx, ay: vy, bx: vx, by: vy, emit: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (pend && job_ready) begin
        pend <= 1'b0;
      end
      if (accept) begin
        prev_x <= vx;
        prev_y <= vy;
        if (!have_prev) begin
          first_x <= vx;
          first_y <= vy;
        end
        if (last_vertex) begin
          have_prev <= 1'b0;
          if (have_prev) begin
            pend     <= 1'b1;
            pend_job <= '{ax: vx, ay: vy, bx: first_x, by: first_y, emit: 1'b1};
          end
        end else begin
          have_prev <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/rpnh_jobq.sv
module rpnh_jobq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpnh_pkg::edge_job_t in_job,
  output logic                out_valid,
  input  logic                out_pop,
  output rpnh_pkg::edge_job_t out_job
);
  import rpnh_pkg::*;
  `include "ray_polygon_nearest_hit_top_assert.svh"

  edge_job_t  slots [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       wr, rd;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job   = slots[rptr];
  assign wr        = in_valid && in_ready;
  assign rd        = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) wptr <= !wptr;
      if (rd) rptr <= !rptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  `RPNH_ASSERT_NOW(a_cnt_bound, 1'b1, count <= 2'd2, "job queue count out of range")
  `RPNH_ASSERT_NOW(a_pop_nonempty, out_pop, count != 2'd0, "job popped from empty queue")
  `RPNH_ASSERT_NEXT(a_cnt_inc, wr && !rd, count == $past(count) + 2'd1, "queue count not bumped")
  `RPNH_ASSERT_NOW(a_ptr_track, count == 2'd0 || count == 2'd2, wptr == rptr, "queue pointers skewed")

endmodule

### rtl/rpnh_back.sv
module rpnh_back (
  input  logic                clk,
  input  logic                rst,
  input  rpnh_pkg::cfg_t      cfg,
  input  logic                job_valid,
  output logic                job_pop,
  input  rpnh_pkg::edge_job_t job_in,
  output logic                res_valid,
  input  logic                res_pop,
  output rpnh_pkg::nearest_t  res_fwd,
  output rpnh_pkg::nearest_t  res_back
);
  import rpnh_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_NUM  = 4'd4;
  localparam logic [3:0] S_PM0  = 4'd5;
  localparam logic [3:0] S_PM1  = 4'd6;
  localparam logic [3:0] S_DCHK = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_RND  = 4'd9;
  localparam logic [3:0] S_PT   = 4'd10;
  localparam logic [3:0] S_BOX  = 4'd11;
  localparam logic [3:0] S_DOT  = 4'd12;
  localparam logic [3:0] S_SUM  = 4'd13;
  localparam logic [3:0] S_KEEP = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  logic [3:0]              state;
  edge_job_t               job;
  logic signed [EW-1:0]    ex, ey, wx, wy;
  logic signed [PW-1:0]    pa, pb;
  logic signed [DEN_W-1:0] den;
  logic [MAG_W-1:0]        den_mag, num_mag;
  logic                    den_neg, num_neg;
  logic                    axis;
  logic [PROD_W-1:0]       prod;
  logic [MAG_W-1:0]        rem;
  logic [QB-1:0]           dvd, q;
  logic [CNT_W-1:0]        cnt;
  logic signed [QS_W-1:0]  qx, qy;
  logic signed [PT_W-1:0]  px, py;
  logic signed [OFS_W-1:0] dxp, dyp;
  logic signed [SA_W-1:0]  sa, sb;
  logic signed [SUM_W-1:0] sum;
  logic signed [CW-1:0]    hxc, hyc;
  nearest_t                best_fwd, best_back;

  // combinational helpers
  logic signed [DW-1:0]    ml_a, ml_b;
  logic signed [EW-1:0]    mr_a, mr_b;
  logic signed [PW-1:0]    m_a, m_b;
  logic signed [DEN_W-1:0] numv;
  logic signed [EW-1:0]    ev;
  logic [EW-1:0]           e_mag;
  logic [NUM_HI-1:0]       mb;
  logic [EW+NUM_HI-1:0]    mres;
  logic [MAG_W:0]          rem2, rdiff;
  logic                    ge, rnd, e_neg, q_neg;
  logic [QB:0]             qr;
  logic signed [QS_W-1:0]  qs;
  logic                    box_ok;
  logic [SUM_W-1:0]        u;
  logic [T_W-1:0]          t_full;
  logic [DIST_W-1:0]       t;
  logic                    res_free;

  function automatic logic in_box(logic signed [PT_W-1:0] v,
                                  logic signed [CW-1:0] e1,
                                  logic signed [CW-1:0] e2);
    logic signed [EW-1:0] a1, a2, lo, hi;
    a1 = {e1[CW-1], e1};
    a2 = {e2[CW-1], e2};
    lo = (a1 < a2 ? a1 : a2) - EW'(1);
    hi = (a1 < a2 ? a2 : a1) + EW'(1);
    return (v >= $signed({{(PT_W-EW){lo[EW-1]}}, lo})) &&
           (v <= $signed({{(PT_W-EW){hi[EW-1]}}, hi}));
  endfunction

  function automatic logic signed [CW-1:0] clamp(logic signed [PT_W-1:0] v);
    if (!v[PT_W-1] && (|v[PT_W-2:CW-1])) return {1'b0, {(CW-1){1'b1}}};
    if (v[PT_W-1] && !(&v[PT_W-2:CW-1])) return {1'b1, {(CW-1){1'b0}}};
    return v[CW-1:0];
  endfunction

  assign job_pop   = (state == S_IDLE) && job_valid;
  assign res_free  = !res_valid || res_pop;

  always_comb begin
    ml_a = (state == S_MUL1) ? cfg.dir_x : cfg.dir_y;
    mr_a = (state == S_MUL1) ? ey : wx;
    ml_b = (state == S_MUL1) ? cfg.dir_y : cfg.dir_x;
    mr_b = (state == S_MUL1) ? ex : wy;
    m_a  = ml_a * mr_a;
    m_b  = ml_b * mr_b;
    numv = DEN_W'(pa) - DEN_W'(pb);

    ev    = axis ? ey : ex;
    e_neg = ev[EW-1];
    e_mag = e_neg ? EW'(-ev) : EW'(ev);
    mb    = (state == S_PM1) ? num_mag[MAG_W-1:NUM_LO] : NUM_HI'(num_mag[NUM_LO-1:0]);
    mres  = e_mag * mb;

    rem2  = {rem, dvd[QB-1]};
    rdiff = rem2 - {1'b0, den_mag};
    ge    = (rem2 >= {1'b0, den_mag});

    // round half away from zero on the magnitude
    rnd   = ({rem, 1'b0} >= {1'b0, den_mag});
    qr    = {1'b0, q} + {{QB{1'b0}}, rnd};
    q_neg = e_neg ^ num_neg ^ den_neg;
    qs    = q_neg ? -$signed({1'b0, qr[QL-1:0]}) : $signed({1'b0, qr[QL-1:0]});

    box_ok = in_box(px, job.ax, job.bx) && in_box(py, job.ay, job.by);

    u      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    t_full = ({1'b0, u} + T_W'(1 << (DF - 1))) >> DF;
    t      = (|t_full[T_W-1:DIST_W]) ? {DIST_W{1'b1}} : t_full[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (job_valid) job <= job_in;
      S_DIFF: begin
        ex <= $signed({job.bx[CW-1], job.bx}) - $signed({job.ax[CW-1], job.ax});
        ey <= $signed({job.by[CW-1], job.by}) - $signed({job.ay[CW-1], job.ay});
        wx <= $signed({job.ax[CW-1], job.ax}) - $signed({cfg.origin_x[CW-1], cfg.origin_x});
        wy <= $signed({job.ay[CW-1], job.ay}) - $signed({cfg.origin_y[CW-1], cfg.origin_y});
      end
      S_MUL1: begin
        pa <= m_a;
        pb <= m_b;
      end
      S_MUL2: begin
        den <= DEN_W'(pa) - DEN_W'(pb);
        pa  <= m_a;
        pb  <= m_b;
      end
      S_NUM: begin
        den_neg <= den[DEN_W-1];
        den_mag <= den[DEN_W-1] ? MAG_W'(-den) : MAG_W'(den);
        num_neg <= numv[DEN_W-1];
        num_mag <= numv[DEN_W-1] ? MAG_W'(-numv) : MAG_W'(numv);
      end
      S_PM0: prod <= PROD_W'(mres);
      S_PM1: prod <= prod + (PROD_W'(mres) << NUM_LO);
      S_DCHK: begin
        rem <= MAG_W'(prod[PROD_W-1:QB]);
        dvd <= prod[QB-1:0];
        cnt <= CNT_W'(QB - 1);
      end
      S_DIV: begin
        rem <= ge ? rdiff[MAG_W-1:0] : rem2[MAG_W-1:0];
        q   <= {q[QB-2:0], ge};
        dvd <= dvd << 1;
        cnt <= cnt - CNT_W'(1);
      end
      S_RND: begin
        if (axis) qy <= qs;
        else qx <= qs;
      end
      S_PT: begin
        px <= $signed({{(PT_W-CW){job.ax[CW-1]}}, job.ax}) + $signed({qx[QS_W-1], qx});
        py <= $signed({{(PT_W-CW){job.ay[CW-1]}}, job.ay}) + $signed({qy[QS_W-1], qy});
      end
      S_BOX: begin
        // a point inside the box fits the offset width
        dxp <= $signed(px[OFS_W-1:0]) - $signed({{2{cfg.origin_x[CW-1]}}, cfg.origin_x});
        dyp <= $signed(py[OFS_W-1:0]) - $signed({{2{cfg.origin_y[CW-1]}}, cfg.origin_y});
        hxc <= clamp(px);
        hyc <= clamp(py);
      end
      S_DOT: begin
        sa <= dxp * cfg.dir_x;
        sb <= dyp * cfg.dir_y;
      end
      S_SUM:  sum <= SUM_W'(sa) + SUM_W'(sb);
      S_KEEP: ;
      S_FIN:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= 1'b0;
      best_fwd  <= '0;
      best_back <= '0;
      res_valid <= 1'b0;
    end else begin
      // a new result loaded in the same cycle keeps the flag set
      if (res_valid && res_pop && !(state == S_FIN && job.emit)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (job_valid) state <= S_DIFF;
        S_DIFF: state <= S_MUL1;
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_NUM;
        S_NUM: begin
          axis  <= 1'b0;
          state <= (den == '0) ? S_FIN : S_PM0;
        end
        S_PM0: state <= S_PM1;
        S_PM1: state <= S_DCHK;
        S_DCHK: state <= (MAG_W'(prod[PROD_W-1:QB]) >= den_mag) ? S_FIN : S_DIV;
        S_DIV: if (cnt == '0) state <= S_RND;
        S_RND: begin
          if (|qr[QB:QL]) begin
            state <= S_FIN;
          end else if (!axis) begin
            axis  <= 1'b1;
            state <= S_PM0;
          end else begin
            state <= S_PT;
          end
        end
        S_PT:  state <= S_BOX;
        S_BOX: state <= box_ok ? S_DOT : S_FIN;
        S_DOT: state <= S_SUM;
        S_SUM: state <= S_KEEP;
        S_KEEP: begin
          if (t != '0) begin
            if (!sum[SUM_W-1]) begin
              if (!best_fwd.found || t < best_fwd.distance) begin
                best_fwd <= '{found: 1'b1, distance: t, hx: hxc, hy: hyc};
              end
            end else if (!best_back.found || t < best_back.distance) begin
              best_back <= '{found: 1'b1, distance: t, hx: hxc, hy: hyc};
            end
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!job.emit) begin
            state <= S_IDLE;
          end else if (res_free) begin
            res_valid <= 1'b1;
            best_fwd  <= '0;
            best_back <= '0;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && job.emit && res_free) begin
      res_fwd  <= best_fwd;
      res_back <= best_back;
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rpnh_pkg::*;

  typedef struct packed {
    nearest_t fwd;
    nearest_t back;
  } hit_pair_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        lst;
    bit          typed;
    hit_pair_t   want;
  } vertex_row_t;

  localparam longint             DIST_MAX = (64'd1 << DIST_W) - 1;
  localparam longint             QUOT_MAX = 64'd1 << QL;
  localparam logic signed [31:0] ONE      = 32'sd65536;
  localparam int                 SETTLE   = 400;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        push;
  logic        full;
  logic [31:0] vertex_x;
  logic [31:0] vertex_y;
  logic        last_vertex;
  logic        empty;
  logic        pop;
  logic        fwd_found;
  logic [32:0] fwd_distance;
  logic [31:0] fwd_hit_x;
  logic [31:0] fwd_hit_y;
  logic        back_found;
  logic [32:0] back_distance;
  logic [31:0] back_hit_x;
  logic [31:0] back_hit_y;

  ray_polygon_nearest_hit_top DUT (.*);

  // shadow of the block state
  logic signed [31:0] org_x, org_y;
  logic signed [15:0] dir_x_r, dir_y_r;
  longint   first_x, first_y, prev_x, prev_y;
  bit       have_prev;
  nearest_t near_fwd, near_back;

  hit_pair_t   hits_due[$];
  vertex_row_t rows[$];
  int send_idle, recv_idle, hold_off;
  int errors, vertices_sent, polygons_checked, config_writes;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic bit ratio_round(input longint a, input longint b, input longint d,
                                     output longint r);
    logic [127:0] ma, mb, md, q, rm;
    bit neg;
    neg = ((a < 0) != (b < 0)) != (d < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    md = (d < 0) ? -d : d;
    q = (ma * mb) / md;
    rm = (ma * mb) % md;
    if (rm >= md - rm) q = q + 1;
    r = 0;
    if (q >= QUOT_MAX) return 0;
    r = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    return 1;
  endfunction

  function automatic bit in_span(input longint v, input longint e1, input longint e2);
    longint lo, hi;
    lo = (e1 < e2) ? e1 : e2;
    hi = (e1 < e2) ? e2 : e1;
    return (v >= lo - 1) && (v <= hi + 1);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void keep_nearer(ref nearest_t n, input longint d, input longint px,
                                      input longint py);
    if (!n.found || d < longint'(n.distance)) begin
      n.found = 1'b1;
      n.distance = d[DIST_W-1:0];
      n.hx = 32'(clamp32(px));
      n.hy = 32'(clamp32(py));
    end
  endfunction

  function automatic void cross_edge(input longint ax, input longint ay, input longint bx,
                                     input longint by);
    longint ox, oy, dx, dy, ex, ey, den, num, qx, qy, px, py, sum, u, t;
    ox = org_x; oy = org_y; dx = dir_x_r; dy = dir_y_r;
    ex = bx - ax;
    ey = by - ay;
    den = dx * ey - dy * ex;
    if (den == 0) return;
    num = (ax - ox) * dy - (ay - oy) * dx;
    if (!ratio_round(ex, num, den, qx) || !ratio_round(ey, num, den, qy)) return;
    px = ax + qx;
    py = ay + qy;
    if (!in_span(px, ax, bx) || !in_span(py, ay, by)) return;
    sum = (px - ox) * dx + (py - oy) * dy;
    u = (sum < 0) ? -sum : sum;
    t = (u + 8192) >> DF;
    if (t == 0) return;
    if (t > DIST_MAX) t = DIST_MAX;
    if (sum > 0) keep_nearer(near_fwd, t, px, py);
    else keep_nearer(near_back, t, px, py);
  endfunction

  function automatic bit polygon_step(input logic [31:0] x, input logic [31:0] y,
                                      input logic lst, output hit_pair_t res);
    longint vx, vy;
    vx = longint'(signed'(x));
    vy = longint'(signed'(y));
    res = '0;
    if (!have_prev) begin
      first_x = vx;
      first_y = vy;
      have_prev = 1;
    end else begin
      cross_edge(prev_x, prev_y, vx, vy);
    end
    prev_x = vx;
    prev_y = vy;
    if (!lst) return 0;
    cross_edge(vx, vy, first_x, first_y);
    res.fwd = near_fwd;
    res.back = near_back;
    have_prev = 0;
    near_fwd = '0;
    near_back = '0;
    return 1;
  endfunction

  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y, input logic lst,
                             input bit typed, input hit_pair_t want);
    hit_pair_t res;
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1;
    vertex_x <= x;
    vertex_y <= y;
    last_vertex <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    if (polygon_step(x, y, lst, res)) hits_due = {hits_due, (typed ? want : res)};
    vertices_sent++;
    @(negedge clk);
  endtask

  // block holds no pending result work once everything expected has come out
  task automatic drain;
    push <= 0;
    while (hits_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [15:0] dx, input logic [15:0] dy);
    logic [31:0] vals [4];
    vals = '{ox, oy, {{16{dx[15]}}, dx}, {{16{dy[15]}}, dy}};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 0;
    org_x = ox; org_y = oy; dir_x_r = dx; dir_y_r = dy;
    config_writes += 4;
  endtask

  task automatic add_row(input logic [31:0] x, input logic [31:0] y, input logic lst,
                         input bit typed = 0, input hit_pair_t want = '0);
    vertex_row_t r;
    r.x = x; r.y = y; r.lst = lst; r.typed = typed; r.want = want;
    rows = {rows, r};
  endtask

  function automatic logic [31:0] near_coord(input logic signed [31:0] c, input int r);
    return 32'(clamp32(longint'(c) + longint'($urandom_range(2 * r)) - r));
  endfunction

  task automatic random_polygon;
    int n, r;
    logic [31:0] x, y;
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
    case ($urandom_range(4))
      0: r = $urandom_range(1, 4);
      1: r = 1 << 16;
      2: r = 1 << 20;
      default: r = 1 << $urandom_range(17, 30);
    endcase
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0) begin
        x = $urandom;
        y = $urandom;
      end else begin
        x = near_coord(org_x, r);
        y = near_coord(org_y, r);
      end
      send_vertex(x, y, i == n - 1, 0, '0);
    end
  endtask

  task automatic random_config;
    real a;
    logic [15:0] dx, dy;
    a = $urandom_range(0, 62831) / 10000.0;
    dx = 16'($rtoi(16384.0 * $cos(a)));
    dy = 16'($rtoi(16384.0 * $sin(a)));
    case ($urandom_range(5))
      0: set_config(32'h7fffffff, 32'h80000000, dx, dy);
      1: set_config(32'h80000000, 32'h7fffffff, dx, dy);
      2: set_config($urandom, $urandom, 16'($urandom), 16'($urandom));
      3: set_config(0, 0, 16'sd16384, 0);
      default: set_config($urandom & 32'h03ffffff, $urandom & 32'h03ffffff, dx, dy);
    endcase
  endtask

  task automatic check_field(input string name, input logic [32:0] want, input logic [32:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    hit_pair_t e;
    if (!rst && pop && !empty) begin
      if (hits_due.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = hits_due.pop_front();
        check_field("fwd_found", e.fwd.found, fwd_found);
        check_field("fwd_distance", e.fwd.distance, fwd_distance);
        check_field("fwd_hit_x", {1'b0, e.fwd.hx}, fwd_hit_x);
        check_field("fwd_hit_y", {1'b0, e.fwd.hy}, fwd_hit_y);
        check_field("back_found", e.back.found, back_found);
        check_field("back_distance", e.back.distance, back_distance);
        check_field("back_hit_x", {1'b0, e.back.hx}, back_hit_x);
        check_field("back_hit_y", {1'b0, e.back.hy}, back_hit_y);
        polygons_checked++;
      end
    end
  end

  initial begin
    pop = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off--;
        pop <= 0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin
    hit_pair_t sq;
    int mode_items;
    int batch_start;
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0; push = 0;
    vertex_x = 0; vertex_y = 0; last_vertex = 0;
    send_idle = 11; recv_idle = 62; hold_off = 0;
    errors = 0; vertices_sent = 0; polygons_checked = 0; config_writes = 0;
    org_x = 0; org_y = 0; dir_x_r = 0; dir_y_r = -16'sd16384;
    have_prev = 0; near_fwd = '0; near_back = '0;
    first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed rows, reset direction points down the y axis
    add_row(32'h00012345, 32'h00054321, 1, 1, '0);
    sq.fwd = '{1'b1, 33'(ONE), 32'sd0, -32'sd65536};
    sq.back = '{1'b1, 33'(ONE), 32'sd0, 32'sd65536};
    add_row(-ONE, -ONE, 0);
    add_row(ONE, -ONE, 0);
    add_row(ONE, ONE, 0);
    add_row(-ONE, ONE, 1, 1, sq);
    add_row(32'h7fffffff, 32'h80000000, 0);
    add_row(32'h80000000, 32'h7fffffff, 0);
    add_row(32'hffffffff, 32'hffffffff, 1);
    add_row(32'h00000005, 32'h00000005, 0);
    add_row(32'h00000005, 32'h00000005, 1);
    add_row(0, 0, 0);
    add_row(ONE, 0, 0);
    add_row(0, ONE, 1);
    add_row(-1, 32'h80000000, 0);
    add_row(1, 32'h7fffffff, 1);
    add_row(-ONE, 2, 0);
    add_row(ONE, 2, 0);
    add_row(ONE, -2, 0);
    add_row(-ONE, -2, 1);
    foreach (rows[i]) send_vertex(rows[i].x, rows[i].y, rows[i].lst, rows[i].typed,
                                  rows[i].want);
    drain();
    set_config(0, 0, 16'sd16384, 0);
    foreach (rows[i]) if (!rows[i].typed) send_vertex(rows[i].x, rows[i].y, rows[i].lst, 0, '0);
    drain();
    set_config(32'h7fffffff, 32'h80000000, -16'sd16384, 0);
    foreach (rows[i]) if (!rows[i].typed) send_vertex(rows[i].x, rows[i].y, rows[i].lst, 0, '0);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 11 : (mode == 1) ? 62 : 0;
      recv_idle = (mode == 0) ? 62 : (mode == 1) ? 11 : 0;
      // long receiver stall so the block backs up and stalls its input
      if (mode == 0) hold_off = 3000;
      mode_items = 0;
      while (mode_items < 360) begin
        random_config();
        batch_start = vertices_sent;
        while (vertices_sent - batch_start < 60) random_polygon();
        mode_items += vertices_sent - batch_start;
        drain();
      end
    end

    $display("tb_top: %0d vertices, %0d polygon results checked, %0d register writes",
             vertices_sent, polygons_checked, config_writes);
    $display("tb_top: three idle mixes, long output stall, extreme origins and directions");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
